// ===== hdl/ptz_command_frame_builder_top_assert.svh =====
// Assertion macros for the PTZ command frame builder checker.
// Each macro expects clk and rst_n in scope of the asserting module.
`ifndef PTZ_COMMAND_FRAME_BUILDER_TOP_ASSERT_SVH
`define PTZ_COMMAND_FRAME_BUILDER_TOP_ASSERT_SVH

// Same-cycle implication, off during reset
`define PTZFB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptz frame check failed");

// Next-cycle implication, off during reset
`define PTZFB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptz frame check failed");

`endif

// ===== hdl/ptzfb_pkg.sv =====
// Shared types and constants for the PTZ command frame builder.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package ptzfb_pkg;

  // Command codes
  localparam logic [7:0] CMD_PAN     = 8'h4B;
  localparam logic [7:0] CMD_TILT    = 8'h4D;
  localparam logic [7:0] CMD_UP      = 8'h08;
  localparam logic [7:0] CMD_DOWN    = 8'h10;
  localparam logic [7:0] CMD_LEFT    = 8'h04;
  localparam logic [7:0] CMD_RIGHT   = 8'h02;
  localparam logic [7:0] CMD_ASKPAN  = 8'h51;
  localparam logic [7:0] CMD_ASKTILT = 8'h53;
  localparam logic [7:0] CMD_NONE    = 8'h00;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;

  // Angle arithmetic, hundredths of a degree
  localparam logic [15:0] FULL_TURN = 16'd36000;
  // Multiple of a full turn that makes the negated 24-bit value positive
  localparam logic [24:0] PAN_BIAS   = 25'd8424000;
  // floor(2^40 / 36000): quotient estimate is exact or one low
  localparam logic [24:0] PAN_RECIP  = 25'd30541989;
  localparam int          PAN_SHIFT  = 40;

  // Speed rounding: (s + 50) / 100 as a reciprocal multiply
  localparam logic [12:0] SPEED_MAX   = 13'd6300;
  localparam logic [12:0] SPEED_ROUND = 13'd50;
  localparam logic [12:0] SPEED_RECIP = 13'd5243;
  localparam int          SPEED_SHIFT = 19;

  // Configuration
  localparam int CFG_WIDTH = 14;
  typedef enum logic [1:0] {
    CFG_DEVICE_ADDRESS   = 2'd0,
    CFG_TILT_ZERO_OFFSET = 2'd1,
    CFG_TILT_LIMIT       = 2'd2
  } cfg_index_t;

  localparam logic [7:0]         RST_DEVICE_ADDRESS   = 8'd1;
  localparam logic signed [10:0] RST_TILT_ZERO_OFFSET = -11'sd300;
  localparam logic [13:0]        RST_TILT_LIMIT       = 14'd8500;

  // Byte positions inside one frame
  typedef enum logic [2:0] {
    FP_SYNC = 3'd0,
    FP_ADDR = 3'd1,
    FP_ZERO = 3'd2,
    FP_CMD  = 3'd3,
    FP_HI   = 3'd4,
    FP_LO   = 3'd5,
    FP_SUM  = 3'd6
  } frame_pos_t;

  // Variable part of a frame handed to the serializer
  typedef struct packed {
    logic [7:0] cmd_byte;
    logic [7:0] data_hi;
    logic [7:0] data_lo;
    logic [7:0] checksum;
  } frame_t;

endpackage

`default_nettype wire

// ===== hdl/ptz_command_frame_builder_top.sv =====
// Top level of the PTZ command frame builder: configuration registers,
// data path and serializer. Depends on ptzfb_pkg, ptzfb_data_path, ptzfb_serializer.
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   input   | in_valid/in_ready, command, value          | in
//   result  | out_valid/out_ready, frame_byte, last_byte | out
//   config  | cfg_we, cfg_index, cfg_wdata               | in
//
// Each command yields seven bytes, one per cycle while out_ready is high; the
// sustained command rate is set by the serializer's one-byte output.
// From the input transfer, the first byte goes through three stages past the
// input register, then the serializer load. Synchronous reset clears
// all valids and loads address 1, zero offset -300, tilt limit 8500. A low
// out_ready holds the current byte; the four stages fill, then in_ready drops.
`default_nettype none

module ptz_command_frame_builder_top
  import ptzfb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_command,
  input  wire logic signed [23:0]   in_value_hundredths,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                out_frame_byte,
  output logic                      out_last_byte,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [CFG_WIDTH-1:0] cfg_wdata
);

  logic [7:0]         device_address_r;
  logic signed [10:0] tilt_zero_offset_r;
  logic [13:0]        tilt_limit_r;

  logic   frm_valid;
  logic   frm_ready;
  frame_t frm;

  // Configuration writes; unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r   <= RST_DEVICE_ADDRESS;
      tilt_zero_offset_r <= RST_TILT_ZERO_OFFSET;
      tilt_limit_r       <= RST_TILT_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS:   device_address_r   <= cfg_wdata[7:0];
        CFG_TILT_ZERO_OFFSET: tilt_zero_offset_r <= $signed(cfg_wdata[10:0]);
        CFG_TILT_LIMIT:       tilt_limit_r       <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  ptzfb_data_path u_data_path (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_value_hundredths (in_value_hundredths),
    .device_address      (device_address_r),
    .tilt_zero_offset    (tilt_zero_offset_r),
    .tilt_limit          (tilt_limit_r),
    .frm_valid           (frm_valid),
    .frm_ready           (frm_ready),
    .frm                 (frm)
  );

  ptzfb_serializer u_serializer (
    .clk            (clk),
    .rst_n          (rst_n),
    .frm_valid      (frm_valid),
    .frm_ready      (frm_ready),
    .frm            (frm),
    .device_address (device_address_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

`default_nettype wire

// ===== hdl/ptzfb_data_path.sv =====
// Four-stage data path: input register, angle/speed arithmetic, frame fields.
// Depends on ptzfb_pkg for constants and the frame_t struct.
`default_nettype none

module ptzfb_data_path
  import ptzfb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_command,
  input  wire logic signed [23:0] in_value_hundredths,
  input  wire logic [7:0]         device_address,
  input  wire logic signed [10:0] tilt_zero_offset,
  input  wire logic [13:0]        tilt_limit,
  output logic                    frm_valid,
  input  wire logic               frm_ready,
  output frame_t                  frm
);

  // Stage registers
  logic               s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic [7:0]         s1_cmd_r, s2_cmd_r, s3_cmd_r, s4_cmd_r;
  logic [23:0]        s1_val_r;
  logic [24:0]        s2_u_r, s3_u_r;
  logic signed [15:0] s2_tilt_r;
  logic [12:0]        s2_spd_x_r;
  logic [8:0]         s3_q_r;
  logic [15:0]        s3_tilt_r, s4_tilt_r;
  logic [5:0]         s3_speed_r, s4_speed_r;
  logic [16:0]        s4_rem_r;

  logic s2_rdy, s3_rdy, s4_rdy;

  // Stage 2 logic
  logic signed [24:0] s2_v_ext, s2_lim, s2_lim_neg, s2_clamp;
  logic signed [15:0] s2_tilt_nxt;
  logic [24:0]        s2_u_nxt;
  logic [12:0]        s2_spd_x_nxt;

  // Stage 3 logic
  logic [49:0]        s3_prod;
  logic [8:0]         s3_q_nxt;
  logic signed [15:0] s3_lim, s3_lim_neg, s3_clamp;
  logic [15:0]        s3_tilt_nxt;
  logic [25:0]        s3_spd_prod;
  logic [5:0]         s3_speed_nxt;

  // Stage 4 logic
  logic [24:0] s4_qmul, s4_rem_full;
  logic [16:0] s4_rem_nxt;

  // Frame assembly
  logic [15:0] pan_data;
  logic [7:0]  cbyte, hi, lo;

  // Ready chain: a stage moves when empty or when the next one moves
  assign s4_rdy   = !s4_vld_r || frm_ready;
  assign s3_rdy   = !s3_vld_r || s4_rdy;
  assign s2_rdy   = !s2_vld_r || s3_rdy;
  assign in_ready = !s1_vld_r || s2_rdy;

  // Clamp tilt, add zero offset; bias negated value for the pan modulo; clamp speed
  always_comb begin
    s2_v_ext   = $signed({s1_val_r[23], s1_val_r});
    s2_lim     = $signed({11'b0, tilt_limit});
    s2_lim_neg = -s2_lim;
    priority if (s2_v_ext > s2_lim) begin
      s2_clamp = s2_lim;
    end else if (s2_v_ext < s2_lim_neg) begin
      s2_clamp = s2_lim_neg;
    end else begin
      s2_clamp = s2_v_ext;
    end
    s2_tilt_nxt = $signed({s2_clamp[14], s2_clamp[14:0]})
                + $signed({{5{tilt_zero_offset[10]}}, tilt_zero_offset});
    s2_u_nxt = PAN_BIAS - $unsigned(s2_v_ext);
    priority if (s1_val_r[23]) begin
      s2_spd_x_nxt = SPEED_ROUND;
    end else if (s2_v_ext > $signed({12'b0, SPEED_MAX})) begin
      s2_spd_x_nxt = SPEED_MAX + SPEED_ROUND;
    end else begin
      s2_spd_x_nxt = s1_val_r[12:0] + SPEED_ROUND;
    end
  end

  // Estimate pan quotient, second tilt clamp and wrap, speed divide
  always_comb begin
    s3_prod    = 50'(s2_u_r) * 50'(PAN_RECIP);
    s3_q_nxt   = s3_prod[PAN_SHIFT+8:PAN_SHIFT];
    s3_lim     = $signed({2'b0, tilt_limit});
    s3_lim_neg = -s3_lim;
    priority if (s2_tilt_r > s3_lim) begin
      s3_clamp = s3_lim;
    end else if (s2_tilt_r < s3_lim_neg) begin
      s3_clamp = s3_lim_neg;
    end else begin
      s3_clamp = s2_tilt_r;
    end
    s3_tilt_nxt  = s3_clamp[15] ? $unsigned(s3_clamp) + FULL_TURN : $unsigned(s3_clamp);
    s3_spd_prod  = 26'(s2_spd_x_r) * 26'(SPEED_RECIP);
    s3_speed_nxt = s3_spd_prod[SPEED_SHIFT+5:SPEED_SHIFT];
  end

  // Remainder before correction, below two full turns
  always_comb begin
    s4_qmul     = 25'(s3_q_r) * 25'(FULL_TURN);
    s4_rem_full = s3_u_r - s4_qmul;
    s4_rem_nxt  = s4_rem_full[16:0];
  end

  // Correct remainder, select data by command, form checksum
  always_comb begin
    pan_data = (s4_rem_r >= 17'(FULL_TURN)) ? 16'(s4_rem_r - 17'(FULL_TURN))
                                            : s4_rem_r[15:0];
    cbyte = s4_cmd_r;
    hi    = 8'd0;
    lo    = 8'd0;
    unique case (s4_cmd_r)
      CMD_PAN: begin
        hi = pan_data[15:8];
        lo = pan_data[7:0];
      end
      CMD_TILT: begin
        hi = s4_tilt_r[15:8];
        lo = s4_tilt_r[7:0];
      end
      CMD_UP, CMD_DOWN, CMD_LEFT, CMD_RIGHT: begin
        hi = {2'b0, s4_speed_r};
        lo = {2'b0, s4_speed_r};
      end
      CMD_ASKPAN, CMD_ASKTILT: begin
        hi = 8'd0;
        lo = 8'd0;
      end
      default: begin
        cbyte = CMD_NONE;
      end
    endcase
    frm.cmd_byte = cbyte;
    frm.data_hi  = hi;
    frm.data_lo  = lo;
    frm.checksum = device_address + cbyte + hi + lo;
  end

  assign frm_valid = s4_vld_r;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (in_ready) s1_vld_r <= in_valid;
      if (s2_rdy)   s2_vld_r <= s1_vld_r;
      if (s3_rdy)   s3_vld_r <= s2_vld_r;
      if (s4_rdy)   s4_vld_r <= s3_vld_r;
    end
  end

  // Stage payloads: load on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r <= in_command;
      s1_val_r <= in_value_hundredths;
    end
    if (s1_vld_r && s2_rdy) begin
      s2_cmd_r   <= s1_cmd_r;
      s2_u_r     <= s2_u_nxt;
      s2_tilt_r  <= s2_tilt_nxt;
      s2_spd_x_r <= s2_spd_x_nxt;
    end
    if (s2_vld_r && s3_rdy) begin
      s3_cmd_r   <= s2_cmd_r;
      s3_u_r     <= s2_u_r;
      s3_q_r     <= s3_q_nxt;
      s3_tilt_r  <= s3_tilt_nxt;
      s3_speed_r <= s3_speed_nxt;
    end
    if (s3_vld_r && s4_rdy) begin
      s4_cmd_r   <= s3_cmd_r;
      s4_rem_r   <= s4_rem_nxt;
      s4_tilt_r  <= s3_tilt_r;
      s4_speed_r <= s3_speed_r;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ptzfb_serializer.sv =====
// Frame serializer: holds one frame and sends its seven bytes one per transfer.
// Depends on ptzfb_pkg for frame_t and the byte position codes.
`default_nettype none

module ptzfb_serializer
  import ptzfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       frm_valid,
  output logic            frm_ready,
  input  wire frame_t     frm,
  input  wire logic [7:0] device_address,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_frame_byte,
  output logic            out_last_byte
);

  frame_t     frm_r;
  frame_pos_t pos_r;
  logic       vld_r;
  logic       at_last;

  assign at_last   = (pos_r == FP_SUM);
  // Take the next frame when empty or while the checksum byte leaves
  assign frm_ready = !vld_r || (out_ready && at_last);

  // Select the byte at the current position
  always_comb begin
    unique case (pos_r)
      FP_SYNC: out_frame_byte = SYNC_BYTE;
      FP_ADDR: out_frame_byte = device_address;
      FP_ZERO: out_frame_byte = 8'd0;
      FP_CMD:  out_frame_byte = frm_r.cmd_byte;
      FP_HI:   out_frame_byte = frm_r.data_hi;
      FP_LO:   out_frame_byte = frm_r.data_lo;
      FP_SUM:  out_frame_byte = frm_r.checksum;
      default: out_frame_byte = 8'd0;
    endcase
  end

  assign out_valid     = vld_r;
  assign out_last_byte = at_last;

  // Advance position on each transfer, reload after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      pos_r <= FP_SYNC;
    end else if (frm_ready) begin
      vld_r <= frm_valid;
      pos_r <= FP_SYNC;
    end else if (out_ready) begin
      pos_r <= frame_pos_t'(pos_r + 3'd1);
    end
  end

  // Frame payload
  always_ff @(posedge clk) begin
    if (frm_valid && frm_ready) begin
      frm_r <= frm;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ptzfb_checker.sv =====
// Port-level checker for the PTZ command frame builder, bound to the top level.
// Depends on ptzfb_pkg and on ptz_command_frame_builder_top_assert.svh for the macros.
`default_nettype none
`include "ptz_command_frame_builder_top_assert.svh"

module ptzfb_checker
  import ptzfb_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_frame_byte,
  input wire logic       out_last_byte
);

  logic [2:0] pos_r;
  logic [7:0] sum_r;
  logic       xfer;

  assign xfer = out_valid && out_ready;

  // Track byte position and running checksum of transferred bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= FP_SYNC;
      sum_r <= 8'd0;
    end else if (xfer) begin
      if (pos_r == FP_SUM) begin
        pos_r <= FP_SYNC;
        sum_r <= 8'd0;
      end else begin
        pos_r <= pos_r + 3'd1;
        if (pos_r != FP_SYNC) sum_r <= sum_r + out_frame_byte;
      end
    end
  end

  // Stalled result holds
  `PTZFB_ASSERT_NXT(a_stall_hold, out_valid && !out_ready,
                    out_valid && $stable(out_frame_byte) && $stable(out_last_byte))
  // Last flag only on the seventh byte
  `PTZFB_ASSERT_IMP(a_last_pos, out_valid, out_last_byte == (pos_r == FP_SUM))
  // Frame opens with sync
  `PTZFB_ASSERT_IMP(a_sync, out_valid && pos_r == FP_SYNC, out_frame_byte == SYNC_BYTE)
  // Third byte is zero
  `PTZFB_ASSERT_IMP(a_zero, out_valid && pos_r == FP_ZERO, out_frame_byte == 8'h00)
  // Checksum covers the second to sixth bytes
  `PTZFB_ASSERT_IMP(a_checksum, out_valid && pos_r == FP_SUM, out_frame_byte == sum_r)

endmodule

bind ptz_command_frame_builder_top ptzfb_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_frame_byte (out_frame_byte),
  .out_last_byte  (out_last_byte)
);

`default_nettype wire

// ===== sim/ptz_command_frame_builder_top_test.sv =====
// Self-checking testbench for ptz_command_frame_builder_top: predicts each frame byte.
// Stimulus is directed and random, and both channels idle and stall at random.
// Depends on ptzfb_pkg and the RTL of the block only.
module ptz_command_frame_builder_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ptzfb_pkg::*;

  localparam int STALL_LIMIT    = 4000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 12;
  localparam int SPEED_STEP     = 100;
  localparam int FRAME_LEN      = 7;

  // Codes that the block must treat as unknown
  localparam logic [7:0] CMD_UP_LEFT    = CMD_UP | CMD_LEFT;
  localparam logic [7:0] CMD_DOWN_RIGHT = CMD_DOWN | CMD_RIGHT;
  localparam logic [7:0] CMD_UNDEFINED  = 8'hFF;
  // Register index with no register behind it
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [7:0]                  in_command = '0;
  logic signed [23:0]          in_value_hundredths = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [7:0]                  out_frame_byte;
  logic                        out_last_byte;
  logic                        cfg_we = 1'b0;
  logic [1:0]                  cfg_index = '0;
  logic [CFG_WIDTH-1:0]        cfg_wdata = '0;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_entry_t;

  frame_entry_t pending_bytes[$];
  frame_entry_t head_byte;

  // Shadow copy of the configuration registers
  logic [7:0]         cur_address = RST_DEVICE_ADDRESS;
  logic signed [10:0] cur_offset  = RST_TILT_ZERO_OFFSET;
  logic [13:0]        cur_limit   = RST_TILT_LIMIT;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int holdoff_request = 0;
  int holdoff_left = 0;
  int idle_cycles = 0;
  int error_count = 0;
  int commands_sent = 0;
  int bytes_seen = 0;

  ptz_command_frame_builder_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_value_hundredths (in_value_hundredths),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_byte      (out_frame_byte),
    .out_last_byte       (out_last_byte),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int clamp_range(int v, int lo, int hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Compute the seven bytes of the frame for one command and queue them
  function automatic void build_frame_bytes(logic [7:0] cmd, logic signed [23:0] val);
    int         v;
    int         data;
    int         lim;
    logic [7:0] cbyte;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] fr [FRAME_LEN];
    v = int'(val);
    lim = int'(cur_limit);
    data = 0;
    cbyte = cmd;
    hi = 8'h00;
    lo = 8'h00;
    case (cmd)
      CMD_PAN: begin
        data = (-v) % int'(FULL_TURN);
        if (data < 0) data += int'(FULL_TURN);
        hi = data[15:8];
        lo = data[7:0];
      end
      CMD_TILT: begin
        data = clamp_range(v, -lim, lim);
        data = clamp_range(data + int'(cur_offset), -lim, lim);
        if (data < 0) data += int'(FULL_TURN);
        hi = data[15:8];
        lo = data[7:0];
      end
      CMD_UP, CMD_DOWN, CMD_LEFT, CMD_RIGHT: begin
        data = clamp_range(v, 0, int'(SPEED_MAX));
        data = (data + int'(SPEED_ROUND)) / SPEED_STEP;
        hi = data[7:0];
        lo = data[7:0];
      end
      CMD_ASKPAN, CMD_ASKTILT: begin
      end
      default: begin
        cbyte = CMD_NONE;
      end
    endcase
    fr[FP_SYNC] = SYNC_BYTE;
    fr[FP_ADDR] = cur_address;
    fr[FP_ZERO] = 8'h00;
    fr[FP_CMD]  = cbyte;
    fr[FP_HI]   = hi;
    fr[FP_LO]   = lo;
    fr[FP_SUM]  = cur_address + cbyte + hi + lo;
    for (int k = 0; k < FRAME_LEN; k++) begin
      pending_bytes.insert(pending_bytes.size(), frame_entry_t'{fr[k], (k == FRAME_LEN - 1)});
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch on byte %0d: %s got 0x%02h, want 0x%02h",
             bytes_seen, field, got, want);
    error_count++;
  endtask

  // Compare each output transfer with the oldest predicted byte
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      bytes_seen++;
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected byte", out_frame_byte, 8'h00);
      end else begin
        head_byte = pending_bytes.pop_front();
        if (out_frame_byte !== head_byte.frame_byte)
          report_mismatch("frame_byte", out_frame_byte, head_byte.frame_byte);
        if (out_last_byte !== head_byte.last_byte)
          report_mismatch("last_byte", {7'b0, out_last_byte}, {7'b0, head_byte.last_byte});
      end
    end
  end

  // Drive out_ready: random idling, or a counted hold-off when requested
  always @(posedge clk) begin
    if (holdoff_request > 0) begin
      holdoff_left = holdoff_request;
      holdoff_request = 0;
    end
    if (holdoff_left > 0) begin
      out_ready <= 1'b0;
      holdoff_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // End the run when no transfer happens on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d bytes still due",
               STALL_LIMIT, pending_bytes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one command, hold it until the transfer, then queue its frame
  task automatic send_command(input logic [7:0] cmd, input logic signed [23:0] val);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_value_hundredths <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    build_frame_bytes(cmd, val);
    commands_sent++;
  endtask

  // Drop valid and wait until every predicted byte has come out
  task automatic finish_batch();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [CFG_WIDTH-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_DEVICE_ADDRESS:   cur_address = data[7:0];
      CFG_TILT_ZERO_OFFSET: cur_offset = data[10:0];
      CFG_TILT_LIMIT:       cur_limit = data[13:0];
      default: begin
      end
    endcase
  endtask

  // Write a register with random bits above its width
  task automatic write_padded(input logic [1:0] idx, input int value, input int width);
    logic [CFG_WIDTH-1:0] w;
    logic [CFG_WIDTH-1:0] mask;
    w = CFG_WIDTH'($urandom);
    mask = CFG_WIDTH'((1 << width) - 1);
    w = (w & ~mask) | (CFG_WIDTH'(value) & mask);
    write_register(idx, w);
  endtask

  function automatic logic [7:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return CMD_PAN;
    if (r < 45) return CMD_TILT;
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0: return CMD_UP;
        1: return CMD_DOWN;
        2: return CMD_LEFT;
        default: return CMD_RIGHT;
      endcase
    end
    if (r < 80) return ($urandom_range(0, 1) != 0) ? CMD_ASKPAN : CMD_ASKTILT;
    return 8'($urandom);
  endfunction

  // Mix full-range values with ones near the clamp, speed and turn boundaries
  function automatic logic signed [23:0] pick_value();
    int x;
    case ($urandom_range(0, 3))
      0: x = $urandom;
      1: begin
        x = $urandom_range(0, 40000);
        x = x - 20000;
      end
      2: begin
        x = $urandom_range(0, 6800);
        x = x - 200;
      end
      default: begin
        x = $urandom_range(0, 466);
        x = (x - 233) * int'(FULL_TURN) + $urandom_range(0, 4) - 2;
      end
    endcase
    return x[23:0];
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_command(pick_command(), pick_value());
  endtask

  // Field extremes, every command and the unknown codes at reset settings
  task automatic test_reset_defaults();
    send_command(CMD_PAN, 0);
    send_command(CMD_PAN, 1);
    send_command(CMD_PAN, -1);
    send_command(CMD_PAN, 36000);
    send_command(CMD_PAN, -36000);
    send_command(CMD_PAN, 8388607);
    send_command(CMD_PAN, -8388608);
    send_command(CMD_TILT, 8388607);
    send_command(CMD_TILT, -8388608);
    send_command(CMD_TILT, 0);
    send_command(CMD_TILT, 8800);
    send_command(CMD_TILT, -8200);
    send_command(CMD_UP, -1);
    send_command(CMD_DOWN, 0);
    send_command(CMD_LEFT, 49);
    send_command(CMD_RIGHT, 50);
    send_command(CMD_UP, 6300);
    send_command(CMD_DOWN, 6350);
    send_command(CMD_LEFT, 8388607);
    send_command(CMD_RIGHT, -8388608);
    send_command(CMD_ASKPAN, 12345);
    send_command(CMD_ASKTILT, -1);
    send_command(CMD_NONE, 4500);
    send_command(CMD_UNDEFINED, -4500);
    send_command(CMD_UP_LEFT, 3000);
    send_command(CMD_DOWN_RIGHT, 3000);
    finish_batch();
  endtask

  // Zero address, offset -1000, zero tilt limit
  task automatic test_low_extremes();
    write_padded(CFG_DEVICE_ADDRESS, 0, 8);
    write_padded(CFG_TILT_ZERO_OFFSET, -1000, 11);
    write_padded(CFG_TILT_LIMIT, 0, 14);
    send_command(CMD_TILT, 8388607);
    send_command(CMD_TILT, -8388608);
    run_random(40);
    finish_batch();
  endtask

  // Full address, offset 1000, nominal largest tilt limit
  task automatic test_high_extremes();
    write_padded(CFG_DEVICE_ADDRESS, 255, 8);
    write_padded(CFG_TILT_ZERO_OFFSET, 1000, 11);
    write_padded(CFG_TILT_LIMIT, 9000, 14);
    send_command(CMD_TILT, 8388607);
    send_command(CMD_TILT, -8388608);
    send_command(CMD_TILT, 8000);
    run_random(40);
    finish_batch();
  endtask

  // Tilt limit beyond 9000, a write to the spare index, and a long receiver stall
  task automatic test_wide_limit_stall();
    int offset;
    offset = $urandom_range(0, 2000);
    offset = offset - 1000;
    write_register(CFG_SPARE, CFG_WIDTH'($urandom));
    write_padded(CFG_DEVICE_ADDRESS, $urandom_range(0, 255), 8);
    write_padded(CFG_TILT_ZERO_OFFSET, offset, 11);
    write_register(CFG_TILT_LIMIT, 14'h3FFF);
    send_command(CMD_TILT, 8388607);
    send_command(CMD_TILT, -8388608);
    holdoff_request = HOLDOFF_CYCLES;
    run_random(20);
    finish_batch();
    run_random(20);
    finish_batch();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 19;
    rx_idle_pct = 87;
    test_reset_defaults();
    test_low_extremes();
    tx_idle_pct = 87;
    rx_idle_pct = 19;
    test_high_extremes();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_wide_limit_stall();
    $display("Checked %0d commands and %0d frame bytes over four register settings,",
             commands_sent, bytes_seen);
    $display("with sender and receiver idling in turn and one long output stall.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ptzfb_pkg.sv
hdl/ptzfb_data_path.sv
hdl/ptzfb_serializer.sv
hdl/ptz_command_frame_builder_top.sv
hdl/ptzfb_checker.sv
sim/ptz_command_frame_builder_top_test.sv
